// ===== src/spbpf_pkg.sv =====
// Package for the spectrum band meter with peak hold and falloff.
// Holds the transaction structs, per-band entry layout, codes and controller types.
// Depends on nothing.
package spbpf_pkg;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  localparam logic CFG_FULL_SCALE = 1'b0;
  localparam logic CFG_HOLD_TICKS = 1'b1;

  localparam logic [9:0] FULL_SCALE_RST = 10'd256;
  localparam logic [7:0] HOLD_TICKS_RST = 8'd12;
  localparam logic [9:0] SPEED_MAX      = 10'd1023;

  typedef struct packed {
    logic        req_type;
    logic [5:0]  band_index;
    logic [15:0] sample_level;
  } in_item_t;

  typedef struct packed {
    logic [5:0] band_number;
    logic [9:0] bar_height;
    logic [9:0] peak_height;
    logic       last_band;
  } out_item_t;

  typedef struct packed {
    logic [9:0] bar;
    logic [9:0] peak;
    logic [9:0] bar_speed;
    logic [9:0] peak_speed;
    logic [7:0] hold;
  } band_entry_t;

  localparam band_entry_t ENTRY_RST = '{
    bar: 10'd1, peak: 10'd0, bar_speed: 10'd1, peak_speed: 10'd1, hold: 8'd0
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic load;
    logic read;
    logic update;
    logic next_band;
  } ctrl_cmd_t;

  typedef struct packed {
    logic item_ok;
    logic is_tick;
    logic last;
  } ctrl_status_t;

endpackage

// ===== src/spbpf_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module spbpf_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/spbpf_ctrl.sv =====
// Controller state machine: accepts transactions and sequences band reads and updates.
// Depends on spbpf_pkg.
module spbpf_ctrl
  import spbpf_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  ctrl_status_t status,
  output ctrl_cmd_t    cmd,
  output logic         busy
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (status.item_ok) begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd.read  = 1'b1;
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        if (status.is_tick && !status.last) begin
          cmd.next_band = 1'b1;
          state_nxt     = ST_READ;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ===== src/spbpf_dp.sv =====
// Datapath: configuration registers, level conversion, band store and result register.
// Depends on spbpf_pkg and spbpf_ram.
module spbpf_dp
  import spbpf_pkg::*;
#(
  parameter int BAND_COUNT = 32,
  parameter int LEVEL_BITS = 10
) (
  input  logic         clk,
  input  logic         rst_n,
  input  in_item_t     in_data,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [9:0]   cfg_data,
  input  ctrl_cmd_t    cmd,
  output ctrl_status_t status,
  output logic         out_valid,
  output out_item_t    out_data
);

  localparam int AW = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
  localparam int LIM_I = (((1 << LEVEL_BITS) - 1) < 1023) ? ((1 << LEVEL_BITS) - 1) : 1023;
  localparam logic [10:0] LEVEL_LIM = 11'(LIM_I);
  localparam logic [6:0]  BAND_CNT7 = 7'(BAND_COUNT);
  localparam logic [5:0]  LAST_BAND = 6'(BAND_COUNT - 1);

  logic [9:0]            full_scale_r, full_scale_nxt;
  logic [7:0]            hold_ticks_r, hold_ticks_nxt;
  logic                  req_type_r, req_type_nxt;
  logic [5:0]            band_r, band_nxt;
  logic [25:0]           prod_r, prod_nxt;
  logic [BAND_COUNT-1:0] valid_r, valid_nxt;
  logic                  rd_valid_r, rd_valid_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic [AW-1:0]         addr;
  logic [47:0]           rdata;
  band_entry_t           cur;
  band_entry_t           upd;
  logic [26:0]           level_sum;
  logic [9:0]            level;

  assign addr = band_r[AW-1:0];

  spbpf_ram #(
    .WIDTH ($bits(band_entry_t)),
    .DEPTH (BAND_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (addr),
    .wdata (upd),
    .re    (cmd.read),
    .raddr (addr),
    .rdata (rdata)
  );

  assign cur = rd_valid_r ? band_entry_t'(rdata) : ENTRY_RST;

  assign level_sum = {1'b0, prod_r} + 27'd65535;
  assign level = (level_sum[26:16] > LEVEL_LIM) ? LEVEL_LIM[9:0] : level_sum[25:16];

  always_comb begin
    upd = cur;
    if (req_type_r == REQ_TICK) begin
      upd.bar = (cur.bar > cur.bar_speed) ? (cur.bar - cur.bar_speed) : 10'd0;
      upd.bar_speed = (cur.bar_speed < SPEED_MAX) ? (cur.bar_speed + 10'd1) : SPEED_MAX;
      if (cur.hold == 8'd0) begin
        upd.peak = (cur.peak > cur.peak_speed) ? (cur.peak - cur.peak_speed) : 10'd0;
        upd.peak_speed = (cur.peak_speed < SPEED_MAX) ? (cur.peak_speed + 10'd1) : SPEED_MAX;
      end else begin
        upd.hold = cur.hold - 8'd1;
      end
    end else begin
      if (level > cur.bar) begin
        upd.bar        = level;
        upd.bar_speed  = 10'd0;
        upd.peak_speed = 10'd0;
      end
      if (level > cur.peak) begin
        upd.peak       = level;
        upd.hold       = hold_ticks_r;
        upd.peak_speed = 10'd0;
      end
    end
  end

  assign status.item_ok = (in_data.req_type == REQ_TICK) || ({1'b0, in_data.band_index} < BAND_CNT7);
  assign status.is_tick = (req_type_r == REQ_TICK);
  assign status.last    = (band_r == LAST_BAND);

  always_comb begin
    full_scale_nxt = full_scale_r;
    hold_ticks_nxt = hold_ticks_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_FULL_SCALE: full_scale_nxt = cfg_data;
        CFG_HOLD_TICKS: hold_ticks_nxt = cfg_data[7:0];
        default: begin
        end
      endcase
    end

    req_type_nxt = req_type_r;
    band_nxt     = band_r;
    prod_nxt     = prod_r;
    if (cmd.load) begin
      req_type_nxt = in_data.req_type;
      band_nxt     = (in_data.req_type == REQ_TICK) ? 6'd0 : in_data.band_index;
      prod_nxt     = 26'(in_data.sample_level) * 26'(full_scale_r);
    end else if (cmd.next_band) begin
      band_nxt = band_r + 6'd1;
    end

    rd_valid_nxt = rd_valid_r;
    if (cmd.read) begin
      rd_valid_nxt = valid_r[addr];
    end

    valid_nxt = valid_r;
    if (cmd.update) begin
      valid_nxt[addr] = 1'b1;
    end

    out_valid_nxt = cmd.update;
    out_data_nxt  = out_data_r;
    if (cmd.update) begin
      out_data_nxt.band_number = band_r;
      out_data_nxt.bar_height  = upd.bar;
      out_data_nxt.peak_height = upd.peak;
      out_data_nxt.last_band   = (req_type_r == REQ_SAMPLE) || status.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_scale_r <= FULL_SCALE_RST;
      hold_ticks_r <= HOLD_TICKS_RST;
      valid_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      full_scale_r <= full_scale_nxt;
      hold_ticks_r <= hold_ticks_nxt;
      valid_r      <= valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_type_r <= req_type_nxt;
    band_r     <= band_nxt;
    prod_r     <= prod_nxt;
    rd_valid_r <= rd_valid_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/spectrum_band_peak_falloff.sv =====
// Top level of the spectrum band meter with peak hold and gravity falloff.
// Depends on spbpf_pkg, spbpf_ctrl, spbpf_dp and spbpf_ram.
//
// A transaction is accepted when start is high and busy is low. A sample
// transaction updates one band from its level; a tick transaction lets every
// bar fall and each peak whose hold is spent, and reports all bands in order.
// Each band takes a RAM read state and then an update state; busy stays high
// until the last update. A result appears on out_data with out_valid high for
// exactly one cycle, in the cycle after its update; the receiver cannot stall.
// A sample for a band at or above BAND_COUNT is accepted and dropped.
// Registers are written through cfg_we, cfg_index and cfg_data; the user must
// do so only while busy is low, as the block itself does not enforce this.
// Synchronous reset restores the register defaults and marks every band as
// holding its reset values; no clearing pass is needed.
module spectrum_band_peak_falloff
  import spbpf_pkg::*;
#(
  parameter int BAND_COUNT = 32,
  parameter int LEVEL_BITS = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_item_t   in_data,
  output logic       out_valid,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [9:0] cfg_data
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  spbpf_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  spbpf_dp #(
    .BAND_COUNT (BAND_COUNT),
    .LEVEL_BITS (LEVEL_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== tb/sv/spbpf_band_check.sv =====
// Band meter checker: watches the request, result and register ports of the block,
// predicts the reported bar and peak heights per band and compares them in order.
// Depends on spbpf_pkg.
module spbpf_band_check
  import spbpf_pkg::*;
#(
  parameter int BAND_COUNT = 32,
  parameter int LEVEL_BITS = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  in_item_t   in_data,
  input  logic       out_valid,
  input  out_item_t  out_data,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [9:0] cfg_data,
  output int         fail_count,
  output int         pending_count,
  output int         readings_checked
);

  localparam int LEVEL_CAP = ((1 << LEVEL_BITS) - 1 > 1023) ? 1023 : (1 << LEVEL_BITS) - 1;

  band_entry_t meter[BAND_COUNT];
  logic [9:0]  scale_q;
  logic [7:0]  hold_q;
  out_item_t   readings_due[$];

  function automatic logic [9:0] fraction_to_level(input logic [15:0] frac);
    logic [27:0] scaled;
    logic [27:0] lvl;
    scaled = 28'(frac) * 28'(scale_q) + 28'd65535;
    lvl = scaled >> 16;
    if (lvl > 28'(LEVEL_CAP)) lvl = 28'(LEVEL_CAP);
    return lvl[9:0];
  endfunction

  function automatic logic [9:0] fall(input logic [9:0] h, input logic [9:0] s);
    return (h > s) ? h - s : 10'd0;
  endfunction

  function automatic logic [9:0] speed_up(input logic [9:0] s);
    return (s < SPEED_MAX) ? s + 10'd1 : SPEED_MAX;
  endfunction

  task automatic predict_readings(input in_item_t item);
    band_entry_t e;
    logic [9:0]  lvl;
    int          b;
    if (item.req_type == REQ_SAMPLE) begin
      b = int'(item.band_index);
      if (b < BAND_COUNT) begin
        e = meter[b];
        lvl = fraction_to_level(item.sample_level);
        if (lvl > e.bar) begin
          e.bar = lvl;
          e.bar_speed = '0;
          e.peak_speed = '0;
        end
        if (lvl > e.peak) begin
          e.peak = lvl;
          e.hold = hold_q;
          e.peak_speed = '0;
        end
        meter[b] = e;
        readings_due.push_back('{band_number: 6'(b), bar_height: e.bar,
                                 peak_height: e.peak, last_band: 1'b1});
      end
    end else begin
      for (b = 0; b < BAND_COUNT; b++) begin
        e = meter[b];
        e.bar = fall(e.bar, e.bar_speed);
        if (e.hold == '0) begin
          e.peak = fall(e.peak, e.peak_speed);
          e.peak_speed = speed_up(e.peak_speed);
        end else begin
          e.hold = e.hold - 8'd1;
        end
        e.bar_speed = speed_up(e.bar_speed);
        meter[b] = e;
        readings_due.push_back('{band_number: 6'(b), bar_height: e.bar,
                                 peak_height: e.peak, last_band: (b == BAND_COUNT - 1)});
      end
    end
  endtask

  task automatic note_failure();
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending_count = 0;
    readings_checked = 0;
  end

  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst_n) begin
      for (int b = 0; b < BAND_COUNT; b++) meter[b] = ENTRY_RST;
      scale_q = FULL_SCALE_RST;
      hold_q = HOLD_TICKS_RST;
      readings_due.delete();
    end else begin
      if (out_valid) begin
        if (readings_due.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result transaction: band %0d bar %0d peak %0d last %0b",
                     out_data.band_number, out_data.bar_height, out_data.peak_height,
                     out_data.last_band);
          note_failure();
        end else begin
          exp_r = readings_due.pop_front();
          readings_checked++;
          if (out_data !== exp_r) begin
            if (fail_count < 10)
              $display("mismatch: expected band %0d bar %0d peak %0d last %0b, got band %0d bar %0d peak %0d last %0b",
                       exp_r.band_number, exp_r.bar_height, exp_r.peak_height, exp_r.last_band,
                       out_data.band_number, out_data.bar_height, out_data.peak_height,
                       out_data.last_band);
            note_failure();
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_FULL_SCALE) scale_q = cfg_data;
        else if (cfg_index == CFG_HOLD_TICKS) hold_q = cfg_data[7:0];
      end
      if (start && !busy) predict_readings(in_data);
    end
    pending_count = readings_due.size();
  end

endmodule

// ===== tb/sv/spectrum_band_peak_falloff_tb.sv =====
// Testbench top for spectrum_band_peak_falloff: drives directed and bursty random
// sample and tick transactions across several register settings and gives the verdict.
// Depends on spbpf_pkg, spbpf_band_check and the block itself.
module spectrum_band_peak_falloff_tb;
  import spbpf_pkg::*;

  localparam int BANDS = 32;
  localparam int LVL_BITS = 10;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  in_item_t   in_data;
  logic       out_valid;
  out_item_t  out_data;
  logic       cfg_we;
  logic       cfg_index;
  logic [9:0] cfg_data;

  int fail_count;
  int pending_count;
  int readings_checked;
  int burst_left;
  int sample_total;
  int absent_total;
  int tick_total;
  int setting_total;

  spectrum_band_peak_falloff #(.BAND_COUNT(BANDS), .LEVEL_BITS(LVL_BITS)) u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  spbpf_band_check #(.BAND_COUNT(BANDS), .LEVEL_BITS(LVL_BITS)) u_band_check (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count),
    .readings_checked(readings_checked)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  initial begin
    #2000000;
    $display("Run timed out with %0d results still outstanding.", pending_count);
    $display("TB_ERROR");
    $finish;
  end

  task automatic drive_item(input in_item_t item);
    start <= 1'b1;
    in_data <= item;
    while (busy) @(negedge clk);
    @(negedge clk);
    if (item.req_type == REQ_TICK) tick_total++;
    else if (int'(item.band_index) >= BANDS) absent_total++;
    else sample_total++;
  endtask

  task automatic paced_item(input in_item_t item);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end else begin
      burst_left--;
    end
    drive_item(item);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_count != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_settings(input logic [9:0] scale, input logic [9:0] hold);
    cfg_we <= 1'b1;
    cfg_index <= CFG_FULL_SCALE;
    cfg_data <= scale;
    @(negedge clk);
    cfg_index <= CFG_HOLD_TICKS;
    cfg_data <= hold;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    setting_total++;
  endtask

  function automatic in_item_t sample_of(input int band, input logic [15:0] frac);
    return '{req_type: REQ_SAMPLE, band_index: 6'(band), sample_level: frac};
  endfunction

  function automatic in_item_t tick_item();
    return '{req_type: REQ_TICK, band_index: 6'($urandom_range(0, 63)),
             sample_level: 16'($urandom)};
  endfunction

  function automatic in_item_t random_item();
    int pick;
    logic [15:0] frac;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0: frac = 16'($urandom_range(0, 255));
      1: frac = 16'hFFFF - 16'($urandom_range(0, 4095));
      default: frac = 16'($urandom);
    endcase
    if (pick < 14) return tick_item();
    if (pick < 20) return sample_of($urandom_range(BANDS, 63), frac);
    if (pick < 60) return sample_of($urandom_range(0, 3), frac);
    return sample_of($urandom_range(0, BANDS - 1), frac);
  endfunction

  task automatic random_phase(input logic [9:0] scale, input logic [9:0] hold, input int count);
    in_item_t item;
    int done;
    write_settings(scale, hold);
    done = 0;
    while (done < count) begin
      item = random_item();
      paced_item(item);
      if (item.req_type == REQ_TICK || int'(item.band_index) < BANDS) done++;
    end
    wait_idle();
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_FULL_SCALE;
    cfg_data = '0;
    burst_left = 0;
    sample_total = 0;
    absent_total = 0;
    tick_total = 0;
    setting_total = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    drive_item(sample_of(0, 16'hFFFF));
    drive_item(sample_of(BANDS - 1, 16'h0001));
    drive_item(sample_of(5, 16'h0000));
    drive_item(sample_of(BANDS, 16'hFFFF));
    drive_item(sample_of(63, 16'h1234));
    drive_item(sample_of(0, 16'h8000));
    drive_item(tick_item());
    drive_item(tick_item());
    drive_item(sample_of(7, 16'h4000));
    drive_item(tick_item());
    drive_item(sample_of(7, 16'h7FFF));
    drive_item(tick_item());
    drive_item(tick_item());
    wait_idle();

    write_settings(10'd1023, 10'd0);
    drive_item(sample_of(BANDS - 1, 16'hFFFF));
    drive_item(sample_of(1, 16'h0001));
    drive_item(tick_item());
    drive_item(tick_item());
    wait_idle();

    write_settings(10'd0, 10'd255);
    drive_item(sample_of(2, 16'hFFFF));
    drive_item(tick_item());
    wait_idle();

    random_phase(10'($urandom_range(1, 1023)), 10'($urandom_range(0, 255)), 27);
    random_phase(10'd1023, 10'd0, 27);
    random_phase(10'd1, 10'd1, 27);
    random_phase(10'($urandom), 10'($urandom), 27);

    wait_idle();
    $display("Covered %0d band samples, %0d samples for absent bands and %0d ticks",
             sample_total, absent_total, tick_total);
    $display("over %0d register settings; %0d results were checked.",
             setting_total, readings_checked);
    if (fail_count == 0 && pending_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
